/* rtl/core/cdn_pkg.sv */
// Calendar date normalizer: shared types, constants and constant-divisor helpers.
// No dependencies; every other file in rtl/core but cdn_if refers to it by scoped name.
`default_nettype none

package cdn_pkg;

  typedef enum logic [1:0] {
    OP_SET_ALL       = 2'd0,
    OP_SET_KEEP_YEAR = 2'd1,
    OP_SET_TIME      = 2'd2,
    OP_ADD_DAYS      = 2'd3
  } cdn_op_e;

  typedef struct packed {
    cdn_op_e     op;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [10:0] day;
    logic [3:0]  month;
    logic [2:0]  year_add;
    logic [13:0] year;
  } cdn_cmd_t;

  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_RESET = 14'd2000;
  localparam logic [5:0]  SAT_MINUTE = 6'd59;
  localparam logic [4:0]  SAT_HOUR   = 5'd23;
  localparam logic [10:0] SAT_DAY    = 11'd31;
  localparam logic [3:0]  SAT_MONTH  = 4'd12;

  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned WEEK_DAYS     = 7;

  localparam int unsigned DIV60_MUL  = 1093;
  localparam int unsigned DIV24_MUL  = 2731;
  localparam int unsigned DIV12_MUL  = 43;
  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV7_MUL   = 37450;

  function automatic logic [4:0] div60(input logic [9:0] x);
    logic [20:0] p;
    p = 21'(x) * 21'(DIV60_MUL);
    return p[20:16];
  endfunction

  function automatic logic [6:0] div24(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(DIV24_MUL);
    return p[22:16];
  endfunction

  function automatic logic [2:0] div12(input logic [5:0] x);
    logic [11:0] p;
    p = 12'(x) * 12'(DIV12_MUL);
    return p[11:9];
  endfunction

  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = 27'(x) * 27'(DIV100_MUL);
    return p[26:19];
  endfunction

  function automatic logic [2:0] mod7(input logic [13:0] x);
    logic [29:0] p;
    logic [13:0] r;
    p = 30'(x) * 30'(DIV7_MUL);
    r = x - 14'(p[29:18]) * 14'(WEEK_DAYS);
    return r[2:0];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [13:0] c;
    q = div100(y);
    c = 14'(q) * 14'(CENTURY);
    return (y[1:0] == 2'b00) && ((c != y) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] sak_offset(input logic [3:0] m);
    logic [2:0] v;
    unique case (m)
      4'd2:    v = 3'd3;
      4'd3:    v = 3'd2;
      4'd4:    v = 3'd5;
      4'd6:    v = 3'd3;
      4'd7:    v = 3'd5;
      4'd8:    v = 3'd1;
      4'd9:    v = 3'd4;
      4'd10:   v = 3'd6;
      4'd11:   v = 3'd2;
      4'd12:   v = 3'd4;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cdn_if.sv */
// Calendar date normalizer: input and result channel interfaces.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface cdn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [9:0]  set_minute;
  logic [9:0]  set_hour;
  logic [9:0]  set_day;
  logic [5:0]  set_month;
  logic [13:0] set_year;
  logic [9:0]  day_offset;

  modport source (output valid, op, set_minute, set_hour, set_day, set_month, set_year,
                  day_offset, input ready);
  modport sink   (input valid, op, set_minute, set_hour, set_day, set_month, set_year,
                  day_offset, output ready);
endinterface

interface cdn_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  minute_out;
  logic [4:0]  hour_out;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic [2:0]  weekday;
  logic [2:0]  first_weekday;
  logic [4:0]  month_length;
  logic        leap;
  logic        year_saturated;

  modport source (output valid, minute_out, hour_out, day_out, month_out, year_out, weekday,
                  first_weekday, month_length, leap, year_saturated, input ready);
  modport sink   (input valid, minute_out, hour_out, day_out, month_out, year_out, weekday,
                  first_weekday, month_length, leap, year_saturated, output ready);
endinterface

`default_nettype wire

/* rtl/core/cdn_front.sv */
// Calendar date normalizer front end: accepts items, carries minutes and hours,
// folds months into years and builds a command. Depends on cdn_pkg and cdn_if.
`default_nettype none

module cdn_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdn_in_if.sink           in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output cdn_pkg::cdn_cmd_t cmd_o
);

  localparam logic [1:0] FE_IDLE = 2'd0;
  localparam logic [1:0] FE_MIN  = 2'd1;
  localparam logic [1:0] FE_HOUR = 2'd2;
  localparam logic [1:0] FE_PUSH = 2'd3;

  logic [1:0] state_q, state_d;

  cdn_pkg::cdn_op_e op_q;
  logic [9:0]  min_q;
  logic [10:0] hour_q;
  logic [10:0] day_q;
  logic [5:0]  mon_q;
  logic [13:0] year_q;
  logic [9:0]  offs_q;
  logic [5:0]  mi_q;
  logic [4:0]  hr_q;
  logic [3:0]  mo_q;
  logic [2:0]  yadd_q;

  logic        accept;
  logic [4:0]  q60;
  logic [10:0] hour_tot;
  logic [5:0]  mi_n;
  logic [5:0]  mon_m1;
  logic [2:0]  q12;
  logic [3:0]  mo_n;
  logic [6:0]  q24;
  logic [4:0]  hr_n;
  logic [10:0] day_n;

  assign in_i.ready  = (state_q == FE_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cmd_valid_o = (state_q == FE_PUSH);

  always_comb begin
    q60      = cdn_pkg::div60(min_q);
    hour_tot = hour_q + 11'(q60);
    mi_n     = 6'(min_q - 10'(q60) * 10'(cdn_pkg::MINS_PER_HOUR));
    mon_m1   = ((mon_q == 6'd0) ? 6'd1 : mon_q) - 6'd1;
    q12      = cdn_pkg::div12(mon_m1);
    mo_n     = 4'(mon_m1 - 6'(q12) * 6'(cdn_pkg::MONTHS)) + 4'd1;
    q24      = cdn_pkg::div24(hour_q);
    hr_n     = 5'(hour_q - 11'(q24) * 11'(cdn_pkg::HOURS_PER_DAY));
    unique case (op_q)
      cdn_pkg::OP_SET_ALL,
      cdn_pkg::OP_SET_KEEP_YEAR: day_n = day_q + 11'(q24);
      cdn_pkg::OP_SET_TIME:      day_n = 11'(q24);
      cdn_pkg::OP_ADD_DAYS:      day_n = 11'(offs_q);
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FE_IDLE: if (accept) state_d = FE_MIN;
      FE_MIN:  state_d = FE_HOUR;
      FE_HOUR: state_d = FE_PUSH;
      FE_PUSH: if (cmd_ready_i) state_d = FE_IDLE;
      default: state_d = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= cdn_pkg::cdn_op_e'(in_i.op);
      min_q  <= in_i.set_minute;
      hour_q <= {1'b0, in_i.set_hour};
      day_q  <= (in_i.set_day == 10'd0) ? 11'd1 : {1'b0, in_i.set_day};
      mon_q  <= in_i.set_month;
      year_q <= (in_i.set_year == 14'd0) ? 14'd1 : in_i.set_year;
      offs_q <= in_i.day_offset;
    end
    if (state_q == FE_MIN) begin
      mi_q   <= mi_n;
      hour_q <= hour_tot;
      mo_q   <= mo_n;
      yadd_q <= q12;
    end
    if (state_q == FE_HOUR) begin
      hr_q  <= hr_n;
      day_q <= day_n;
    end
  end

  always_comb begin
    cmd_o.op       = op_q;
    cmd_o.minute   = mi_q;
    cmd_o.hour     = hr_q;
    cmd_o.day      = day_q;
    cmd_o.month    = mo_q;
    cmd_o.year_add = yadd_q;
    cmd_o.year     = year_q;
  end

endmodule

`default_nettype wire

/* rtl/core/cdn_fifo.sv */
// Calendar date normalizer command queue between front and back end.
// Register-based FIFO of cdn_pkg::cdn_cmd_t entries; Depth must be 2 or more.
`default_nettype none

module cdn_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  cdn_pkg::cdn_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output cdn_pkg::cdn_cmd_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdn_pkg::cdn_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cdn_back.sv */
// Calendar date normalizer back end: holds the current date, walks days through
// months and years, derives weekday data and drives the result register. Uses cdn_pkg.
`default_nettype none

module cdn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cdn_pkg::cdn_cmd_t cmd_i,
  cdn_out_if.source         out_o
);

  localparam logic [2:0] BE_IDLE = 3'd0;
  localparam logic [2:0] BE_LEAP = 3'd1;
  localparam logic [2:0] BE_STEP = 3'd2;
  localparam logic [2:0] BE_WK1  = 3'd3;
  localparam logic [2:0] BE_WK2  = 3'd4;
  localparam logic [2:0] BE_WK3  = 3'd5;
  localparam logic [2:0] BE_OUT  = 3'd6;

  logic [2:0] state_q, state_d;

  logic [5:0]  cur_minute_q;
  logic [4:0]  cur_hour_q;
  logic [4:0]  cur_day_q;
  logic [3:0]  cur_month_q;
  logic [13:0] cur_year_q;
  logic        out_valid_q;

  logic [5:0]  mi_w_q;
  logic [4:0]  hr_w_q;
  logic [10:0] d_w_q;
  logic [3:0]  mo_w_q;
  logic [13:0] y_w_q;
  logic        sat_w_q;
  logic        leap_w_q;
  logic [13:0] yy_q;
  logic [7:0]  q100_q;
  logic [13:0] s_q;
  logic [2:0]  b7_q;

  logic [5:0]  minute_q;
  logic [4:0]  hour_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  logic [2:0]  weekday_q;
  logic [2:0]  first_q;
  logic [4:0]  mlen_q;
  logic        leap_q;
  logic        ysat_q;

  logic        take;
  logic [5:0]  ld_mi;
  logic [4:0]  ld_hr;
  logic [10:0] ld_d;
  logic [3:0]  ld_mo;
  logic [14:0] ld_y;
  logic        ld_sat;
  logic [4:0]  len;
  logic        fits;
  logic        year_end;
  logic        y_last;
  logic [13:0] yy;
  logic [14:0] s_sum;
  logic        out_free;
  logic        finish;

  assign cmd_ready_o = (state_q == BE_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_free    = !out_valid_q || out_o.ready;
  assign finish      = (state_q == BE_OUT) && out_free;

  always_comb begin
    ld_mi = cmd_i.minute;
    ld_hr = cmd_i.hour;
    ld_d  = cmd_i.day;
    ld_mo = cmd_i.month;
    ld_y  = {1'b0, cur_year_q};
    unique case (cmd_i.op)
      cdn_pkg::OP_SET_ALL: begin
        ld_y = {1'b0, cmd_i.year} + 15'(cmd_i.year_add);
      end
      cdn_pkg::OP_SET_KEEP_YEAR: begin
        ld_y = {1'b0, cur_year_q} + 15'(cmd_i.year_add);
      end
      cdn_pkg::OP_SET_TIME: begin
        ld_d  = 11'(cur_day_q) + cmd_i.day;
        ld_mo = cur_month_q;
      end
      cdn_pkg::OP_ADD_DAYS: begin
        ld_mi = cur_minute_q;
        ld_hr = cur_hour_q;
        ld_d  = 11'(cur_day_q) + cmd_i.day;
        ld_mo = cur_month_q;
      end
    endcase
    ld_sat = (ld_y > 15'(cdn_pkg::YEAR_MAX));
  end

  always_comb begin
    len      = cdn_pkg::month_len(mo_w_q, leap_w_q);
    fits     = (d_w_q <= 11'(len));
    year_end = (mo_w_q == 4'd12);
    y_last   = (y_w_q == cdn_pkg::YEAR_MAX);
    yy       = y_w_q - ((mo_w_q < 4'd3) ? 14'd1 : 14'd0);
    s_sum    = 15'(yy_q) + 15'(yy_q[13:2]) - 15'(q100_q) + 15'(q100_q[7:2])
             + 15'(cdn_pkg::sak_offset(mo_w_q));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BE_IDLE: if (take) state_d = BE_LEAP;
      BE_LEAP: state_d = BE_STEP;
      BE_STEP: begin
        priority if (fits) state_d = BE_WK1;
        else if (year_end) state_d = BE_LEAP;
        else state_d = BE_STEP;
      end
      BE_WK1:  state_d = BE_WK2;
      BE_WK2:  state_d = BE_WK3;
      BE_WK3:  state_d = BE_OUT;
      BE_OUT:  if (out_free) state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BE_IDLE;
      out_valid_q  <= 1'b0;
      cur_minute_q <= 6'd0;
      cur_hour_q   <= 5'd0;
      cur_day_q    <= 5'd1;
      cur_month_q  <= 4'd1;
      cur_year_q   <= cdn_pkg::YEAR_RESET;
    end else begin
      state_q <= state_d;
      if (finish) begin
        out_valid_q  <= 1'b1;
        cur_minute_q <= mi_w_q;
        cur_hour_q   <= hr_w_q;
        cur_day_q    <= d_w_q[4:0];
        cur_month_q  <= mo_w_q;
        cur_year_q   <= y_w_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BE_IDLE: begin
        if (take) begin
          if (ld_sat) begin
            mi_w_q  <= cdn_pkg::SAT_MINUTE;
            hr_w_q  <= cdn_pkg::SAT_HOUR;
            d_w_q   <= cdn_pkg::SAT_DAY;
            mo_w_q  <= cdn_pkg::SAT_MONTH;
            y_w_q   <= cdn_pkg::YEAR_MAX;
            sat_w_q <= 1'b1;
          end else begin
            mi_w_q  <= ld_mi;
            hr_w_q  <= ld_hr;
            d_w_q   <= ld_d;
            mo_w_q  <= ld_mo;
            y_w_q   <= ld_y[13:0];
            sat_w_q <= 1'b0;
          end
        end
      end
      BE_LEAP: leap_w_q <= cdn_pkg::is_leap(y_w_q);
      BE_STEP: begin
        if (!fits) begin
          priority if (year_end && y_last) begin
            mi_w_q  <= cdn_pkg::SAT_MINUTE;
            hr_w_q  <= cdn_pkg::SAT_HOUR;
            d_w_q   <= cdn_pkg::SAT_DAY;
            mo_w_q  <= cdn_pkg::SAT_MONTH;
            sat_w_q <= 1'b1;
          end else if (year_end) begin
            d_w_q  <= d_w_q - 11'(len);
            mo_w_q <= 4'd1;
            y_w_q  <= y_w_q + 14'd1;
          end else begin
            d_w_q  <= d_w_q - 11'(len);
            mo_w_q <= mo_w_q + 4'd1;
          end
        end
      end
      BE_WK1: begin
        yy_q   <= yy;
        q100_q <= cdn_pkg::div100(yy);
      end
      BE_WK2: s_q  <= s_sum[13:0];
      BE_WK3: b7_q <= cdn_pkg::mod7(s_q);
      BE_OUT: begin
        if (out_free) begin
          minute_q  <= mi_w_q;
          hour_q    <= hr_w_q;
          day_q     <= d_w_q[4:0];
          month_q   <= mo_w_q;
          year_q    <= y_w_q;
          weekday_q <= cdn_pkg::mod7(14'(b7_q) + 14'(d_w_q[4:0]));
          first_q   <= (b7_q == 3'd6) ? 3'd0 : b7_q + 3'd1;
          mlen_q    <= len;
          leap_q    <= leap_w_q;
          ysat_q    <= sat_w_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.minute_out     = minute_q;
  assign out_o.hour_out       = hour_q;
  assign out_o.day_out        = day_q;
  assign out_o.month_out      = month_q;
  assign out_o.year_out       = year_q;
  assign out_o.weekday        = weekday_q;
  assign out_o.first_weekday  = first_q;
  assign out_o.month_length   = mlen_q;
  assign out_o.leap           = leap_q;
  assign out_o.year_saturated = ysat_q;

endmodule

`default_nettype wire

/* rtl/core/calendar_date_normalizer.sv */
// Calendar date normalizer top level: front end, command queue, back end.
// Depends on cdn_pkg, cdn_if, cdn_front, cdn_fifo and cdn_back.
//
//   Channel  Port   Dir  Moves
//   input    in_i   in   op, set_minute/hour/day/month/year, day_offset
//   result   out_o  out  normalized date, weekday, first_weekday, month_length, flags
//
// Front end steps per item: load, minute carry, hour carry, hand-off; it takes a new item only after the hand-off.
// Back end steps: load, leap check, day walk (one month per cycle, back to the leap check at each
// year end), weekday steps WK1 to WK3, output; it takes a new command only after its result is registered.
// Results come out in order through an output register; either side may stall.
// Reset: date 00:00, 1 January 2000; queue and result register empty.
`default_nettype none

module calendar_date_normalizer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdn_in_if.sink     in_i,
  cdn_out_if.source  out_o
);

  logic              fe_valid, fe_ready;
  cdn_pkg::cdn_cmd_t fe_cmd;
  logic              be_valid, be_ready;
  cdn_pkg::cdn_cmd_t be_cmd;

  cdn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  cdn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_cmd)
  );

  cdn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* tb/tb_calendar_date_normalizer.sv */
// Self-checking testbench for calendar_date_normalizer: directed table, then random items.
// Depends on cdn_pkg and cdn_if; a local date model predicts results not fixed in the table.
`timescale 1ns / 100ps

module tb_calendar_date_normalizer;

  localparam real         CLK_PERIOD   = 4.0;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned N_RANDOM     = 630;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned N_DIR        = 23;
  localparam int unsigned YEAR_TOP     = 32'(cdn_pkg::YEAR_MAX);
  localparam int unsigned YEAR_START   = 32'(cdn_pkg::YEAR_RESET);

  typedef struct packed {
    cdn_pkg::cdn_op_e op;
    logic [9:0]       minute;
    logic [9:0]       hour;
    logic [9:0]       day;
    logic [5:0]       month;
    logic [13:0]      year;
    logic [9:0]       offset;
  } date_cmd_t;

  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic [2:0]  first_weekday;
    logic [4:0]  mlen;
    logic        leap;
    logic        sat;
  } date_res_t;

  typedef struct packed {
    date_cmd_t cmd;
    logic      typed;
    date_res_t res;
  } dir_row_t;

  localparam date_res_t RES_Y2K  = '{6'd0, 5'd0, 5'd1, 4'd1, 14'd2000, 3'd6, 3'd6, 5'd31,
                                     1'b1, 1'b0};
  localparam date_res_t RES_Y1   = '{6'd0, 5'd0, 5'd1, 4'd1, 14'd1, 3'd1, 3'd1, 5'd31,
                                     1'b0, 1'b0};
  localparam date_res_t RES_TOP  = '{6'd59, 5'd23, 5'd31, 4'd12, 14'd9999, 3'd5, 3'd3, 5'd31,
                                     1'b0, 1'b0};
  localparam date_res_t RES_SAT  = '{6'd59, 5'd23, 5'd31, 4'd12, 14'd9999, 3'd5, 3'd3, 5'd31,
                                     1'b0, 1'b1};
  localparam date_res_t RES_LEAP = '{6'd30, 5'd12, 5'd29, 4'd2, 14'd2000, 3'd2, 3'd2, 5'd29,
                                     1'b1, 1'b0};

  dir_row_t dir_tab [N_DIR] = '{
    '{'{cdn_pkg::OP_SET_TIME,      10'd0,    10'd0,    10'd1,    6'd1,  14'd2000,  10'd0},
      1'b1, RES_Y2K},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd0,    6'd0,  14'd2000,  10'd0},
      1'b1, RES_Y2K},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd1,    6'd1,  14'd0,     10'd0},
      1'b1, RES_Y1},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd1,    6'd1,  14'd16383, 10'd0},
      1'b1, RES_SAT},
    '{'{cdn_pkg::OP_ADD_DAYS,      10'd0,    10'd0,    10'd1,    6'd1,  14'd2000,  10'd0},
      1'b1, RES_TOP},
    '{'{cdn_pkg::OP_ADD_DAYS,      10'd0,    10'd0,    10'd1,    6'd1,  14'd2000,  10'd1},
      1'b1, RES_SAT},
    '{'{cdn_pkg::OP_SET_ALL,       10'd59,   10'd23,   10'd31,   6'd12, 14'd9999,  10'd0},
      1'b1, RES_TOP},
    '{'{cdn_pkg::OP_SET_ALL,       10'd60,   10'd23,   10'd31,   6'd12, 14'd9999,  10'd0},
      1'b1, RES_SAT},
    '{'{cdn_pkg::OP_SET_ALL,       10'd30,   10'd12,   10'd29,   6'd2,  14'd2000,  10'd0},
      1'b1, RES_LEAP},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd29,   6'd2,  14'd1900,  10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd31,   6'd7,  14'd2021,  10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_ADD_DAYS,      10'd0,    10'd0,    10'd0,    6'd0,  14'd0,     10'd1},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_ALL,       10'd1023, 10'd1023, 10'd1023, 6'd63, 14'd2000,  10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_KEEP_YEAR, 10'd0,    10'd0,    10'd1,    6'd13, 14'd16383, 10'd1023},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_TIME,      10'd1023, 10'd1023, 10'd1023, 6'd63, 14'd16383, 10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_ADD_DAYS,      10'd1023, 10'd1023, 10'd1023, 6'd63, 14'd16383, 10'd1023},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_ALL,       10'd1023, 10'd1023, 10'd1023, 6'd63, 14'd9994,  10'd0},
      1'b1, RES_SAT},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd1,    6'd1,  14'd9999,  10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_KEEP_YEAR, 10'd59,   10'd23,   10'd31,   6'd12, 14'd0,     10'd0},
      1'b1, RES_TOP},
    '{'{cdn_pkg::OP_SET_TIME,      10'd60,   10'd23,   10'd0,    6'd0,  14'd0,     10'd0},
      1'b1, RES_SAT},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd28,   6'd2,  14'd2100,  10'd0},
      1'b0, '0},
    '{'{cdn_pkg::OP_ADD_DAYS,      10'd0,    10'd0,    10'd0,    6'd0,  14'd0,     10'd1},
      1'b0, '0},
    '{'{cdn_pkg::OP_SET_ALL,       10'd0,    10'd0,    10'd1,    6'd1,  14'd2000,  10'd0},
      1'b1, RES_Y2K}
  };

  int unsigned month_shift [12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

  logic clk_i = 1'b0;
  logic rst_ni;

  cdn_in_if  in_if ();
  cdn_out_if out_if ();

  calendar_date_normalizer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  int unsigned cal_minute;
  int unsigned cal_hour;
  int unsigned cal_day;
  int unsigned cal_month;
  int unsigned cal_year;

  date_res_t   pending_dates [$];
  int unsigned err_count;
  int unsigned idle_pct;
  bit          hold_req;

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic int unsigned weekday_of(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned yy;
    yy = (m < 3) ? y - 1 : y;
    return (yy + yy / 4 - yy / 100 + yy / 400 + month_shift[(m - 1) % 12] + d) % 7;
  endfunction

  function automatic void clamp_date();
    cal_minute = 59;
    cal_hour   = 23;
    cal_day    = 31;
    cal_month  = 12;
    cal_year   = YEAR_TOP;
  endfunction

  // Carry minute -> hour -> day -> month -> year; return 1 when the year clamps.
  function automatic bit settle_date(input int unsigned mi, input int unsigned hr,
                                     input int unsigned d, input int unsigned mo,
                                     input int unsigned y);
    if (d == 0) d = 1;
    if (mo == 0) mo = 1;
    if (y == 0) y = 1;
    if (y > YEAR_TOP) begin
      clamp_date();
      return 1'b1;
    end
    hr = hr + mi / 60;
    mi = mi % 60;
    d  = d + hr / 24;
    hr = hr % 24;
    y  = y + (mo - 1) / 12;
    mo = (mo - 1) % 12 + 1;
    if (y > YEAR_TOP) begin
      clamp_date();
      return 1'b1;
    end
    while (d > days_in_month(mo, y)) begin
      d  = d - days_in_month(mo, y);
      mo = mo + 1;
      if (mo > 12) begin
        mo = 1;
        y  = y + 1;
        if (y > YEAR_TOP) begin
          clamp_date();
          return 1'b1;
        end
      end
    end
    cal_minute = mi;
    cal_hour   = hr;
    cal_day    = d;
    cal_month  = mo;
    cal_year   = y;
    return 1'b0;
  endfunction

  function automatic date_res_t predict_date(input date_cmd_t c);
    date_res_t r;
    bit        sat;
    sat = 1'b0;
    case (c.op)
      cdn_pkg::OP_SET_ALL:
        sat = settle_date(32'(c.minute), 32'(c.hour), 32'(c.day), 32'(c.month),
                          32'(c.year));
      cdn_pkg::OP_SET_KEEP_YEAR:
        sat = settle_date(32'(c.minute), 32'(c.hour), 32'(c.day), 32'(c.month), cal_year);
      cdn_pkg::OP_SET_TIME:
        sat = settle_date(32'(c.minute), 32'(c.hour), cal_day, cal_month, cal_year);
      cdn_pkg::OP_ADD_DAYS:
        sat = settle_date(cal_minute, cal_hour, cal_day + 32'(c.offset), cal_month,
                          cal_year);
    endcase
    r.minute        = 6'(cal_minute);
    r.hour          = 5'(cal_hour);
    r.day           = 5'(cal_day);
    r.month         = 4'(cal_month);
    r.year          = 14'(cal_year);
    r.weekday       = 3'(weekday_of(cal_day, cal_month, cal_year));
    r.first_weekday = 3'(weekday_of(1, cal_month, cal_year));
    r.mlen          = 5'(days_in_month(cal_month, cal_year));
    r.leap          = leap_year(cal_year);
    r.sat           = sat;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                             input int unsigned full);
    if ($urandom_range(0, 99) < 70) return $urandom_range(lo, hi);
    return $urandom_range(0, full);
  endfunction

  function automatic date_cmd_t rand_cmd();
    date_cmd_t   c;
    int unsigned r;
    c.op     = cdn_pkg::cdn_op_e'(2'($urandom_range(0, 3)));
    c.minute = 10'(pick_field(0, 59, 1023));
    c.hour   = 10'(pick_field(0, 23, 1023));
    c.day    = 10'(pick_field(1, 31, 1023));
    c.month  = 6'(pick_field(1, 12, 63));
    c.offset = ($urandom_range(0, 99) < 60) ? 10'($urandom_range(0, 40))
                                            : 10'($urandom_range(0, 1023));
    r = $urandom_range(0, 99);
    if (r < 78)      c.year = 14'($urandom_range(1, 9999));
    else if (r < 88) c.year = 14'($urandom_range(9980, 9999));
    else if (r < 92) c.year = 14'd0;
    else             c.year = 14'($urandom_range(0, 16383));
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR @%0t: %s got %0d, expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Call at a falling edge; return at the falling edge after the transfer.
  task automatic send_cmd(input date_cmd_t c, input logic typed, input date_res_t fixed);
    int unsigned gap;
    date_res_t   predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= c.op;
    in_if.set_minute <= c.minute;
    in_if.set_hour   <= c.hour;
    in_if.set_day    <= c.day;
    in_if.set_month  <= c.month;
    in_if.set_year   <= c.year;
    in_if.day_offset <= c.offset;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predicted = predict_date(c);
    pending_dates.push_back(typed ? fixed : predicted);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stim_proc
    in_if.valid      = 1'b0;
    in_if.op         = cdn_pkg::OP_SET_ALL;
    in_if.set_minute = '0;
    in_if.set_hour   = '0;
    in_if.set_day    = '0;
    in_if.set_month  = '0;
    in_if.set_year   = '0;
    in_if.day_offset = '0;
    rst_ni           = 1'b0;
    err_count        = 0;
    idle_pct         = 30;
    hold_req         = 1'b0;
    cal_minute       = 0;
    cal_hour         = 0;
    cal_day          = 1;
    cal_month        = 1;
    cal_year         = YEAR_START;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (int k = 0; k < N_RANDOM; k++) begin
      idle_pct = ((k / 90) % 3) * 25;
      if (k == 200) hold_req = 1'b1;
      if (k == 400) drain();
      send_cmd(rand_cmd(), 1'b0, '0);
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : sink_proc
    int unsigned stall_left;
    int unsigned g;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_if.ready <= 1'b0;
          stall_left = g - 1;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    date_res_t got;
    date_res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = '{out_if.minute_out, out_if.hour_out, out_if.day_out, out_if.month_out,
              out_if.year_out, out_if.weekday, out_if.first_weekday, out_if.month_length,
              out_if.leap, out_if.year_saturated};
      if (pending_dates.size() == 0) begin
        report_mismatch("transfer with nothing pending, year_out", 32'(got.year), 0);
      end else begin
        want = pending_dates.pop_front();
        if (got.minute !== want.minute)
          report_mismatch("minute_out", 32'(got.minute), 32'(want.minute));
        if (got.hour !== want.hour)
          report_mismatch("hour_out", 32'(got.hour), 32'(want.hour));
        if (got.day !== want.day)
          report_mismatch("day_out", 32'(got.day), 32'(want.day));
        if (got.month !== want.month)
          report_mismatch("month_out", 32'(got.month), 32'(want.month));
        if (got.year !== want.year)
          report_mismatch("year_out", 32'(got.year), 32'(want.year));
        if (got.weekday !== want.weekday)
          report_mismatch("weekday", 32'(got.weekday), 32'(want.weekday));
        if (got.first_weekday !== want.first_weekday)
          report_mismatch("first_weekday", 32'(got.first_weekday), 32'(want.first_weekday));
        if (got.mlen !== want.mlen)
          report_mismatch("month_length", 32'(got.mlen), 32'(want.mlen));
        if (got.leap !== want.leap)
          report_mismatch("leap", 32'(got.leap), 32'(want.leap));
        if (got.sat !== want.sat)
          report_mismatch("year_saturated", 32'(got.sat), 32'(want.sat));
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/cdn_pkg.sv
rtl/core/cdn_if.sv
rtl/core/cdn_front.sv
rtl/core/cdn_fifo.sv
rtl/core/cdn_back.sv
rtl/core/calendar_date_normalizer.sv
tb/tb_calendar_date_normalizer.sv
